// ===== rtl/core/sft_pkg.sv =====
// sft_pkg: shared types, codes and constants of the stuffed frame transmitter.
// No dependencies; every module of the block uses it by scoped names.
`default_nettype none

package sft_pkg;

    // Command codes of an input beat
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;
    localparam logic [1:0] CMD_ACK     = 2'd3;

    // Result kinds
    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    // Configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_FLAG      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FLAG_SUB  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ESC_SUB   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ADDRESS   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CTL_ZERO  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CTL_ONE   = 3'd6;

    // Register reset values
    localparam logic [7:0] RST_FLAG     = 8'd126;
    localparam logic [7:0] RST_ESCAPE   = 8'd125;
    localparam logic [7:0] RST_FLAG_SUB = 8'd94;
    localparam logic [7:0] RST_ESC_SUB  = 8'd93;
    localparam logic [7:0] RST_ADDRESS  = 8'd3;
    localparam logic [7:0] RST_CTL_ZERO = 8'd0;
    localparam logic [7:0] RST_CTL_ONE  = 8'd64;

    // Run descriptor: up to four result beats caused by one input beat
    localparam int RUN_BYTES = 4;
    localparam int RUN_IDX_W = 2;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] payload_byte;
        logic       ack_next_seq;
    } in_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] line_byte;
        logic       last_of_run;
        logic       ack_accepted;
    } out_item_t;

    typedef struct packed {
        logic                          kind;
        logic                          ack;
        logic [RUN_IDX_W-1:0]          last_idx;
        logic [RUN_BYTES-1:0][7:0]     bytes;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/sft_front.sv =====
// sft_front: config registers, frame state and classification of input beats.
// Turns each accepted beat into a run descriptor; depends on sft_pkg.
`default_nettype none

module sft_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [sft_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                   cfg_data,
    input  wire logic                         push,
    input  wire sft_pkg::in_item_t            item,
    input  wire sft_pkg::fifo_stat_t          fifo_stat,
    output logic                              full,
    output logic                              run_wr,
    output sft_pkg::run_t                     run_data
);

    logic [7:0] flag_reg, escape_reg, flag_sub_reg, esc_sub_reg;
    logic [7:0] address_reg, ctl_zero_reg, ctl_one_reg;
    logic       seq_reg, seq_next;
    logic [7:0] check_reg, check_next;

    logic [7:0] ctl;
    logic [7:0] sb;
    logic       is_flag, is_esc, stuffed;
    logic [7:0] sub;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg     <= sft_pkg::RST_FLAG;
            escape_reg   <= sft_pkg::RST_ESCAPE;
            flag_sub_reg <= sft_pkg::RST_FLAG_SUB;
            esc_sub_reg  <= sft_pkg::RST_ESC_SUB;
            address_reg  <= sft_pkg::RST_ADDRESS;
            ctl_zero_reg <= sft_pkg::RST_CTL_ZERO;
            ctl_one_reg  <= sft_pkg::RST_CTL_ONE;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                sft_pkg::REG_FLAG:     flag_reg     <= cfg_data;
                sft_pkg::REG_ESCAPE:   escape_reg   <= cfg_data;
                sft_pkg::REG_FLAG_SUB: flag_sub_reg <= cfg_data;
                sft_pkg::REG_ESC_SUB:  esc_sub_reg  <= cfg_data;
                sft_pkg::REG_ADDRESS:  address_reg  <= cfg_data;
                sft_pkg::REG_CTL_ZERO: ctl_zero_reg <= cfg_data;
                sft_pkg::REG_CTL_ONE:  ctl_one_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign full   = fifo_stat.full;
    assign run_wr = push && !fifo_stat.full;

    // Stuffing decision; flag match wins over escape match
    assign ctl     = seq_reg ? ctl_one_reg : ctl_zero_reg;
    assign sb      = (item.command == sft_pkg::CMD_END) ? check_reg : item.payload_byte;
    assign is_flag = (sb == flag_reg);
    assign is_esc  = (sb == escape_reg);
    assign stuffed = is_flag || is_esc;
    assign sub     = is_flag ? flag_sub_reg : esc_sub_reg;

    // Build the run descriptor and next frame state
    always_comb
    begin
        run_data   = '0;
        check_next = check_reg;
        seq_next   = seq_reg;
        unique case (item.command)
            sft_pkg::CMD_START:
            begin
                run_data.kind     = sft_pkg::KIND_LINE;
                run_data.bytes[0] = flag_reg;
                run_data.bytes[1] = address_reg;
                run_data.bytes[2] = ctl;
                run_data.bytes[3] = address_reg ^ ctl;
                run_data.last_idx = sft_pkg::RUN_IDX_W'(3);
                check_next        = '0;
            end
            sft_pkg::CMD_PAYLOAD:
            begin
                run_data.kind = sft_pkg::KIND_LINE;
                check_next    = check_reg ^ item.payload_byte;
                if (stuffed)
                begin
                    run_data.bytes[0] = escape_reg;
                    run_data.bytes[1] = sub;
                    run_data.last_idx = sft_pkg::RUN_IDX_W'(1);
                end
                else
                begin
                    run_data.bytes[0] = sb;
                    run_data.last_idx = sft_pkg::RUN_IDX_W'(0);
                end
            end
            sft_pkg::CMD_END:
            begin
                run_data.kind = sft_pkg::KIND_LINE;
                check_next    = '0;
                if (stuffed)
                begin
                    run_data.bytes[0] = escape_reg;
                    run_data.bytes[1] = sub;
                    run_data.bytes[2] = flag_reg;
                    run_data.last_idx = sft_pkg::RUN_IDX_W'(2);
                end
                else
                begin
                    run_data.bytes[0] = sb;
                    run_data.bytes[1] = flag_reg;
                    run_data.last_idx = sft_pkg::RUN_IDX_W'(1);
                end
            end
            sft_pkg::CMD_ACK:
            begin
                run_data.kind     = sft_pkg::KIND_ACK;
                run_data.ack      = (item.ack_next_seq != seq_reg);
                run_data.last_idx = sft_pkg::RUN_IDX_W'(0);
                // the bit ends up equal to the requested number either way
                seq_next          = item.ack_next_seq;
            end
            default: ;
        endcase
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= 1'b0;
            check_reg <= '0;
        end
        else if (run_wr)
        begin
            seq_reg   <= seq_next;
            check_reg <= check_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sft_run_fifo.sv =====
// sft_run_fifo: short queue of run descriptors between front and back.
// Head entry is shown while not empty; depends on sft_pkg.
`default_nettype none

module sft_run_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire sft_pkg::run_t wr_data,
    input  wire logic          rd,
    output sft_pkg::run_t      rd_data,
    output sft_pkg::fifo_stat_t stat
);

    sft_pkg::run_t                   mem_reg [sft_pkg::FIFO_DEPTH];
    logic [sft_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [sft_pkg::FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                            do_wr, do_rd;

    assign stat.full  = (count_reg == sft_pkg::FIFO_CNT_W'(sft_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sft_back.sv =====
// sft_back: walks the head run descriptor into the result register, one beat a cycle
// while the result register is empty or popped. Depends on sft_pkg.
`default_nettype none

module sft_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sft_pkg::run_t       head,
    input  wire sft_pkg::fifo_stat_t fifo_stat,
    output logic                     run_rd,
    input  wire logic                pop,
    output logic                     empty,
    output sft_pkg::out_item_t       result
);

    logic [sft_pkg::RUN_IDX_W-1:0] idx_reg;
    logic                          out_valid_reg;
    sft_pkg::out_item_t            out_reg, out_next;
    logic                          load;
    logic                          at_last;

    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign load    = !fifo_stat.empty && (!out_valid_reg || pop);
    assign at_last = (idx_reg == head.last_idx);
    assign run_rd  = load && at_last;

    // Next result beat from the head descriptor
    always_comb
    begin
        out_next.result_kind  = head.kind;
        out_next.line_byte    = head.bytes[idx_reg];
        out_next.last_of_run  = at_last;
        out_next.ack_accepted = head.ack;
    end

    // Beat index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= at_last ? '0 : idx_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/stuffed_frame_transmitter.sv =====
// stuffed_frame_transmitter: top level of the byte-stuffing frame transmitter.
// Instantiates sft_front, sft_run_fifo and sft_back; depends on sft_pkg.
//
//   channel   direction  handshake          payload
//   --------  ---------  -----------------  -------------------------------
//   item      in         push / full        in_item_t (command, byte, seq)
//   result    out        empty / pop        out_item_t (kind, byte, flags)
//   cfg       in         cfg_write_en       cfg_index (3b), cfg_data (8b)
//
// An input beat causes a run of results in the back end: 4 for start,
// 1 or 2 for payload, 2 or 3 for end, 1 for ack. The result register
// emits one beat a cycle while it is popped; the front accepts a beat
// every cycle while the four-entry descriptor queue has room.
// Reset restores the register defaults and clears sequence bit and check.
// Either side may stall at any time; a stalled result holds its value.
`default_nettype none

module stuffed_frame_transmitter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [sft_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire sft_pkg::in_item_t             item,
    output logic                               empty,
    input  wire logic                          pop,
    output sft_pkg::out_item_t                 result
);

    sft_pkg::run_t       run_wdata, run_head;
    sft_pkg::fifo_stat_t fifo_stat;
    logic                run_wr, run_rd;

    // Front: classify beats into run descriptors
    sft_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .item         (item),
        .fifo_stat    (fifo_stat),
        .full         (full),
        .run_wr       (run_wr),
        .run_data     (run_wdata)
    );

    // Descriptor queue
    sft_run_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (run_wr),
        .wr_data (run_wdata),
        .rd      (run_rd),
        .rd_data (run_head),
        .stat    (fifo_stat)
    );

    // Back: serialize descriptors into result beats
    sft_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (run_head),
        .fifo_stat (fifo_stat),
        .run_rd    (run_rd),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    // Checks
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(run_wr && fifo_stat.full))
        else $error("descriptor written into a full queue");

    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        run_rd |-> !fifo_stat.empty)
        else $error("descriptor retired from an empty queue");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !result.last_of_run) |=> !empty)
        else $error("run broken off before its last beat");

    a_ack_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.result_kind == sft_pkg::KIND_ACK) |->
            (result.last_of_run && result.line_byte == 8'd0))
        else $error("ack status beat malformed");

endmodule

`default_nettype wire
